FILE: rtl/lha_pkg.sv
// ----------------------------------------------------------------------------
// lha_pkg
// Shared types, constants and arithmetic helpers of the linear Hall angle
// block: item formats, CORDIC lane and divider state, arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package lha_pkg;

  // angle accumulator resolution and CORDIC depth
  localparam int unsigned ANGLE_BITS    = 16;
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned STAGE_BITS    = 5;
  localparam int unsigned DIV_STAGES    = ANGLE_BITS;

  // datapath width of the rotation lanes, covers the CORDIC gain
  localparam int unsigned CW = 36;

  // round(2^16 / sqrt3)
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // configuration
  localparam int unsigned PP_BITS   = 6;
  localparam int unsigned EB_BITS   = 5;
  localparam int unsigned CFG_BITS  = 6;
  localparam int unsigned IDX_BITS  = 1;
  localparam logic [PP_BITS-1:0] PP_RESET  = 6'd7;
  localparam logic [EB_BITS-1:0] EB_RESET  = 5'd14;
  localparam logic [EB_BITS-1:0] EB_MIN    = 5'd12;
  localparam logic [EB_BITS-1:0] EB_MAX    = 5'd16;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_POLE_PAIRS   = 1'b0,
    CFG_ENCODER_BITS = 1'b1
  } cfg_idx_e;

  // one input item
  typedef struct packed {
    logic signed [15:0] motor_hall_a;
    logic signed [15:0] motor_hall_b;
    logic signed [15:0] motor_hall_c;
    logic signed [15:0] gear_hall_sin;
    logic signed [15:0] gear_hall_cos;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [15:0] elec_angle;
    logic [15:0] mech_angle;
    logic [15:0] gear_angle;
    logic [15:0] encoder_count;
  } out_item_t;

  // one vectoring lane
  typedef struct packed {
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic [ANGLE_BITS-1:0]  z;
    logic                   fixed;
  } lane_t;

  // what a CORDIC cell hands to its neighbour
  typedef struct packed {
    logic  valid;
    lane_t motor;
    lane_t gear;
  } cord_t;

  // what a divider cell hands to its neighbour
  typedef struct packed {
    logic                  valid;
    logic [PP_BITS-1:0]    rem;
    logic [ANGLE_BITS-1:0] num;
    logic [ANGLE_BITS-1:0] quo;
    logic [PP_BITS-1:0]    dvsr;
    logic [ANGLE_BITS-1:0] elec;
    logic [ANGLE_BITS-1:0] gear;
  } div_t;

  // atan(2^-i) in 2^32 counts per turn, rounded to ANGLE_BITS
  function automatic logic [ANGLE_BITS-1:0] atan_entry(input logic [STAGE_BITS-1:0] i);
    logic [32:0] t;
    logic [32:0] s;
    case (i)
      5'd0:    t = 33'd536870912;
      5'd1:    t = 33'd316933406;
      5'd2:    t = 33'd167458907;
      5'd3:    t = 33'd85004756;
      5'd4:    t = 33'd42667331;
      5'd5:    t = 33'd21354465;
      5'd6:    t = 33'd10680094;
      5'd7:    t = 33'd5340245;
      5'd8:    t = 33'd2670163;
      5'd9:    t = 33'd1335087;
      5'd10:   t = 33'd667544;
      5'd11:   t = 33'd333772;
      5'd12:   t = 33'd166886;
      5'd13:   t = 33'd83443;
      5'd14:   t = 33'd41721;
      5'd15:   t = 33'd20860;
      5'd16:   t = 33'd10430;
      5'd17:   t = 33'd5215;
      5'd18:   t = 33'd2607;
      5'd19:   t = 33'd1303;
      5'd20:   t = 33'd651;
      5'd21:   t = 33'd325;
      5'd22:   t = 33'd162;
      5'd23:   t = 33'd81;
      default: t = 33'd0;
    endcase
    s = (t + (33'd1 << (32 - ANGLE_BITS - 1))) >> (32 - ANGLE_BITS);
    return s[ANGLE_BITS-1:0];
  endfunction

  // one micro-rotation towards the x axis
  function automatic lane_t cordic_step(input lane_t l, input logic [STAGE_BITS-1:0] i);
    lane_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    r  = l;
    dx = l.y >>> i;
    dy = l.x >>> i;
    if (!l.fixed) begin
      if (l.y >= 0) begin
        r.x = l.x + dx;
        r.y = l.y - dy;
        r.z = l.z + atan_entry(i);
      end else begin
        r.x = l.x - dx;
        r.y = l.y + dy;
        r.z = l.z - atan_entry(i);
      end
    end
    return r;
  endfunction

  // take the top bits of an ANGLE_BITS angle as a w-bit value
  function automatic logic [15:0] angle_to_bits(input logic [ANGLE_BITS-1:0] v,
                                                input logic [EB_BITS-1:0] w);
    logic [31:0] a;
    a = 32'(v) << (32 - ANGLE_BITS);
    a = a >> (6'd32 - 6'(w));
    return a[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lha_stream_if.sv
// ----------------------------------------------------------------------------
// lha_stream_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lha_in_if;
  logic               valid;
  logic               ready;
  lha_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lha_out_if;
  logic               valid;
  logic               ready;
  lha_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lha_cordic_cell.sv
// ----------------------------------------------------------------------------
// lha_cordic_cell
// One CORDIC stage for the motor and gear lanes, registered towards the
// next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lha_cordic_cell (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                en_i,
  input  wire  [lha_pkg::STAGE_BITS-1:0]     stage_i,
  input  lha_pkg::cord_t                     cell_i,
  output lha_pkg::cord_t                     cell_o
);

  lha_pkg::cord_t cell_d;
  lha_pkg::cord_t cell_q;

  // rotate both lanes by this stage's angle
  always_comb begin
    cell_d       = cell_i;
    cell_d.motor = lha_pkg::cordic_step(cell_i.motor, stage_i);
    cell_d.gear  = lha_pkg::cordic_step(cell_i.gear, stage_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

FILE: rtl/lha_div_cell.sv
// ----------------------------------------------------------------------------
// lha_div_cell
// One restoring division step: produces one quotient bit of the mechanical
// angle and passes the partial remainder on.
// ----------------------------------------------------------------------------
`default_nettype none

module lha_div_cell (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            en_i,
  input  lha_pkg::div_t  cell_i,
  output lha_pkg::div_t  cell_o
);

  lha_pkg::div_t          cell_d;
  lha_pkg::div_t          cell_q;
  logic [lha_pkg::PP_BITS:0] part;
  logic                   take;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    cell_d = cell_i;
    part   = {cell_i.rem, cell_i.num[lha_pkg::ANGLE_BITS-1]};
    take   = (part >= {1'b0, cell_i.dvsr});
    cell_d.rem = take ? lha_pkg::PP_BITS'(part - {1'b0, cell_i.dvsr})
                      : lha_pkg::PP_BITS'(part);
    cell_d.num = cell_i.num << 1;
    cell_d.quo = {cell_i.quo[lha_pkg::ANGLE_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

FILE: rtl/linear_hall_angle.sv
// ----------------------------------------------------------------------------
// linear_hall_angle
// Electrical, mechanical, gear and encoder angles from linear Hall readings.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken every cycle unless the output stalls.
// Each item passes through an input scaling stage, a quadrant stage, a chain
// of CORDIC cells that each run one rotation for the motor and the gear
// vector, a chain of divider cells that each produce one bit of the
// mechanical angle, and the output register. The whole pipeline holds while
// a result waits at the output. Angles are 65536 counts per turn;
// pole_pairs of zero acts as one and encoder_bits is clamped to 12..16.
// Write configuration only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_hall_angle (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [lha_pkg::IDX_BITS-1:0]     cfg_idx_i,
  input  wire  [lha_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  lha_in_if.sink                           in_i,
  lha_out_if.source                        out_o
);

  localparam int unsigned CS = lha_pkg::CORDIC_STAGES;
  localparam int unsigned DS = lha_pkg::DIV_STAGES;
  localparam int unsigned CW = lha_pkg::CW;

  logic                          adv;
  logic [lha_pkg::PP_BITS-1:0]   pole_pairs_q;
  logic [lha_pkg::EB_BITS-1:0]   enc_bits_q;
  logic [lha_pkg::EB_BITS-1:0]   enc_bits;

  // input scaling stage
  logic                  sc_valid_q;
  logic signed [CW-1:0]  mx_q, my_q, gx_q, gy_q;
  logic signed [16:0]    bc_sum;
  logic signed [33:0]    bc_prod;

  lha_pkg::cord_t        cord [CS+1];
  lha_pkg::cord_t        prep_d;
  lha_pkg::cord_t        prep_q;
  lha_pkg::div_t         div [DS+1];

  logic                  out_valid_q;
  lha_pkg::out_item_t    out_q;
  lha_pkg::out_item_t    out_d;

  // whole pipeline moves unless a result is stuck at the output
  assign adv      = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_pairs_q <= lha_pkg::PP_RESET;
      enc_bits_q   <= lha_pkg::EB_RESET;
    end else if (cfg_we_i) begin
      case (lha_pkg::cfg_idx_e'(cfg_idx_i))
        lha_pkg::CFG_POLE_PAIRS:   pole_pairs_q <= lha_pkg::PP_BITS'(cfg_wdata_i);
        lha_pkg::CFG_ENCODER_BITS: enc_bits_q   <= lha_pkg::EB_BITS'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // scale motor x by 1/sqrt3, all vectors by 2^16
  assign bc_sum  = 17'(in_i.data.motor_hall_b) + 17'(in_i.data.motor_hall_c);
  assign bc_prod = bc_sum * $signed({1'b0, lha_pkg::INV_SQRT3_Q16});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_valid_q <= 1'b0;
    end else if (adv) begin
      sc_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q <= CW'(bc_prod);
      my_q <= CW'($signed({in_i.data.motor_hall_a, 16'h0000}));
      gx_q <= CW'($signed({in_i.data.gear_hall_cos, 16'h0000}));
      gy_q <= CW'($signed({in_i.data.gear_hall_sin, 16'h0000}));
    end
  end

  // quadrant fold: left half plane starts at a half turn, y zero is final
  always_comb begin
    prep_d.valid       = sc_valid_q;
    prep_d.motor.fixed = (my_q == '0);
    prep_d.motor.z     = (mx_q < 0) ? lha_pkg::HALF_TURN : '0;
    prep_d.motor.x     = (mx_q < 0 && my_q != '0) ? -mx_q : mx_q;
    prep_d.motor.y     = (mx_q < 0) ? -my_q : my_q;
    prep_d.gear.fixed  = (gy_q == '0);
    prep_d.gear.z      = (gx_q < 0) ? lha_pkg::HALF_TURN : '0;
    prep_d.gear.x      = (gx_q < 0 && gy_q != '0) ? -gx_q : gx_q;
    prep_d.gear.y      = (gx_q < 0) ? -gy_q : gy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
    end else if (adv) begin
      prep_q <= prep_d;
    end
  end

  assign cord[0] = prep_q;

  // chain of CORDIC cells
  for (genvar c = 0; c < CS; c++) begin : g_cordic
    lha_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (lha_pkg::STAGE_BITS'(c)),
      .cell_i  (cord[c]),
      .cell_o  (cord[c+1])
    );
  end

  // mirror the angles and load the divider
  always_comb begin
    div[0].valid = cord[CS].valid;
    div[0].elec  = lha_pkg::HALF_TURN - cord[CS].motor.z;
    div[0].gear  = lha_pkg::HALF_TURN - cord[CS].gear.z;
    div[0].num   = div[0].elec;
    div[0].rem   = '0;
    div[0].quo   = '0;
    div[0].dvsr  = (pole_pairs_q == '0) ? lha_pkg::PP_BITS'(1) : pole_pairs_q;
  end

  // chain of divider cells
  for (genvar k = 0; k < DS; k++) begin : g_div
    lha_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .cell_i (div[k]),
      .cell_o (div[k+1])
    );
  end

  // clamp encoder width
  always_comb begin
    if (enc_bits_q < lha_pkg::EB_MIN) begin
      enc_bits = lha_pkg::EB_MIN;
    end else if (enc_bits_q > lha_pkg::EB_MAX) begin
      enc_bits = lha_pkg::EB_MAX;
    end else begin
      enc_bits = enc_bits_q;
    end
  end

  // result formatting
  always_comb begin
    out_d.elec_angle    = lha_pkg::angle_to_bits(div[DS].elec, 5'd16);
    out_d.mech_angle    = lha_pkg::angle_to_bits(div[DS].quo, 5'd16);
    out_d.gear_angle    = lha_pkg::angle_to_bits(div[DS].gear, 5'd16);
    out_d.encoder_count = lha_pkg::angle_to_bits(div[DS].quo, enc_bits);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div[DS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // divider never sees a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div[0].valid |-> (div[0].dvsr != '0))
    else $error("divider loaded with zero divisor");

  // quotient and remainder reproduce the electrical angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div[DS].valid |->
      ((32'(div[DS].quo) * 32'(div[DS].dvsr) + 32'(div[DS].rem)) == 32'(div[DS].elec)
       && div[DS].rem < div[DS].dvsr))
    else $error("mechanical angle division inconsistent");

  // mechanical angle never exceeds electrical angle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.mech_angle <= out_q.elec_angle))
    else $error("mechanical angle above electrical angle");

  // encoder count fits the configured width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((32'(out_q.encoder_count) >> enc_bits) == 32'd0))
    else $error("encoder count wider than configured");

endmodule

`default_nettype wire

FILE: dv/tb_linear_hall_angle.sv
// ----------------------------------------------------------------------------
// tb_linear_hall_angle
// Drives random and corner-case Hall reading sets into the angle block and
// checks every result item against a bit-exact CORDIC predictor, across
// several pole pair and encoder width settings, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class angle_scoreboard;
  lha_pkg::out_item_t angles_due[$];
  int errors;
  bit [5:0] pole_pairs;
  bit [4:0] enc_bits;

  function new();
    errors     = 0;
    pole_pairs = 6'd7;
    enc_bits   = 5'd14;
  endfunction

  // sign extended arithmetic shift
  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint atan_q(int i);
    longint t;
    case (i)
      0: t = 536870912;  1: t = 316933406;  2: t = 167458907;  3: t = 85004756;
      4: t = 42667331;   5: t = 21354465;   6: t = 10680094;   7: t = 5340245;
      8: t = 2670163;    9: t = 1335087;    10: t = 667544;    11: t = 333772;
      12: t = 166886;    13: t = 83443;     14: t = 41721;     15: t = 20860;
      default: t = 0;
    endcase
    return (t + 32768) >> 16;
  endfunction

  // vectoring arctangent, 65536 counts per turn
  static function longint arctan2(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? 32768 : 0;
    if (x < 0) begin
      z = (y > 0) ? 32768 : -32768;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q(i);
      end else begin
        x -= dx; y += dy; z -= atan_q(i);
      end
    end
    return z;
  endfunction

  // note an accepted item
  function void note_input(lha_pkg::in_item_t it);
    lha_pkg::out_item_t r;
    longint a, bc, elec, gear, mech, pp;
    int eb;
    a    = longint'(it.motor_hall_a);
    bc   = longint'(it.motor_hall_b) + longint'(it.motor_hall_c);
    elec = (32768 - arctan2(a * 65536, bc * 37837)) & 16'hFFFF;
    gear = (32768 - arctan2(longint'(it.gear_hall_sin) * 65536,
                            longint'(it.gear_hall_cos) * 65536)) & 16'hFFFF;
    pp   = (pole_pairs == 0) ? 1 : pole_pairs;
    mech = elec / pp;
    eb   = enc_bits < 12 ? 12 : (enc_bits > 16 ? 16 : enc_bits);
    r.elec_angle    = elec[15:0];
    r.mech_angle    = mech[15:0];
    r.gear_angle    = gear[15:0];
    r.encoder_count = 16'(mech >> (16 - eb));
    angles_due.push_back(r);
  endfunction

  // compare a result item with the oldest prediction
  function void check_result(lha_pkg::out_item_t got);
    lha_pkg::out_item_t exp_r;
    if (angles_due.size() == 0) begin
      $display("%0t unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = angles_due.pop_front();
    if (got.elec_angle !== exp_r.elec_angle) begin
      $display("%0t elec_angle exp %h got %h", $time, exp_r.elec_angle, got.elec_angle);
      errors++;
    end
    if (got.mech_angle !== exp_r.mech_angle) begin
      $display("%0t mech_angle exp %h got %h", $time, exp_r.mech_angle, got.mech_angle);
      errors++;
    end
    if (got.gear_angle !== exp_r.gear_angle) begin
      $display("%0t gear_angle exp %h got %h", $time, exp_r.gear_angle, got.gear_angle);
      errors++;
    end
    if (got.encoder_count !== exp_r.encoder_count) begin
      $display("%0t encoder_count exp %h got %h", $time, exp_r.encoder_count,
               got.encoder_count);
      errors++;
    end
  endfunction
endclass

module tb_linear_hall_angle;

  localparam int LATENCY   = lha_pkg::CORDIC_STAGES + lha_pkg::ANGLE_BITS + 3;
  localparam int MAX_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lha_pkg::IDX_BITS-1:0] cfg_idx_i = '0;
  logic [lha_pkg::CFG_BITS-1:0] cfg_wdata_i = '0;
  int cycles = 0;
  bit burst_on = 1'b0;
  int burst_left = 0;
  bit stall_mode = 1'b0;

  lha_in_if  hall_if ();
  lha_out_if angle_if ();

  angle_scoreboard sb = new();

  linear_hall_angle dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (hall_if.sink),
    .out_o      (angle_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    hall_if.valid  = 1'b0;
    hall_if.data   = '0;
    angle_if.ready = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls in a pattern, sometimes never
  always @(posedge clk_i) begin
    if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 1);
    angle_if.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    if (rst_ni && angle_if.valid && angle_if.ready) sb.check_result(angle_if.data);
  end

  task automatic write_reg(input lha_pkg::cfg_idx_e idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= lha_pkg::CFG_BITS'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == lha_pkg::CFG_POLE_PAIRS) sb.pole_pairs = 6'(value);
    else sb.enc_bits = 5'(value);
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.angles_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // send one item, honouring the burst and gap pattern
  task automatic send_readings(input lha_pkg::in_item_t it);
    while (!burst_on) begin
      @(posedge clk_i);
      if ($urandom_range(0, 2) == 0) begin
        burst_on   = 1'b1;
        burst_left = $urandom_range(1, 40);
      end
    end
    hall_if.valid <= 1'b1;
    hall_if.data  <= it;
    do @(posedge clk_i); while (!hall_if.ready);
    sb.note_input(it);
    burst_left--;
    if (burst_left == 0) begin
      burst_on = 1'b0;
      hall_if.valid <= 1'b0;
    end
  endtask

  // valid is already low whenever no burst is running
  task automatic idle_sender();
    if (burst_on) begin
      hall_if.valid <= 1'b0;
      burst_on = 1'b0;
    end
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic lha_pkg::in_item_t rand_item();
    lha_pkg::in_item_t it;
    it.motor_hall_a  = rand_field();
    it.motor_hall_b  = rand_field();
    it.motor_hall_c  = rand_field();
    it.gear_hall_sin = rand_field();
    it.gear_hall_cos = rand_field();
    if ($urandom_range(0, 9) == 0) it.motor_hall_a = 16'h0;
    if ($urandom_range(0, 9) == 0) it.gear_hall_sin = 16'h0;
    if ($urandom_range(0, 9) == 0) it.motor_hall_c = -it.motor_hall_b;
    return it;
  endfunction

  function automatic lha_pkg::in_item_t mk(int a, int b, int c, int s, int co);
    lha_pkg::in_item_t it;
    it = {16'(a), 16'(b), 16'(c), 16'(s), 16'(co)};
    return it;
  endfunction

  initial begin
    int pp_set[6] = '{1, 32, 0, 63, 7, 5};
    int eb_set[6] = '{12, 16, 3, 31, 14, 13};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero vectors, axis cases, extremes
    send_readings(mk(0, 0, 0, 0, 0));
    send_readings(mk(0, 100, 0, 0, 100));
    send_readings(mk(0, -100, 0, 0, -100));
    send_readings(mk(100, 0, 0, 100, 0));
    send_readings(mk(-100, 0, 0, -100, 0));
    send_readings(mk(32767, 32767, 32767, 32767, 32767));
    send_readings(mk(-32768, -32768, -32768, -32768, -32768));
    send_readings(mk(32767, -32768, -32768, -32768, 32767));
    send_readings(mk(-32768, 32767, 32767, 32767, -32768));
    send_readings(mk(1, -1, -1, -1, -1));
    send_readings(mk(-1, 1, 0, 1, 1));
    send_readings(mk(5, 7, -7, 1, -32768));
    send_readings(mk(-32768, 0, 0, 32767, 0));
    idle_sender();
    drain();

    // sweep settings, extremes included, random sets in each
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(lha_pkg::CFG_POLE_PAIRS, pp_set[ph]);
      write_reg(lha_pkg::CFG_ENCODER_BITS, eb_set[ph]);
      for (int n = 0; n < 300; n++) begin
        send_readings(rand_item());
        if (n == 150) begin
          idle_sender();
          while (sb.angles_due.size() != 0) @(posedge clk_i);
        end
      end
      idle_sender();
      drain();
    end

    if (sb.errors == 0 && sb.angles_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
